/* sv/pdvm_pkg.sv */
// Package for the perspective divide / viewport map block.
// Holds float types, constants and the single-precision helper functions
// used by all pipeline modules. Depends on nothing.
package pdvm_pkg;

  localparam logic [31:0] FP_ONE    = 32'h3F80_0000;
  localparam logic [31:0] FP_HALF   = 32'h3F00_0000;
  localparam logic [31:0] FP_QNAN   = 32'h7FC0_0000;
  localparam logic [31:0] FP_SIGN   = 32'h8000_0000;
  localparam logic [31:0] FP_DMAX_RST = 32'h3F80_0000;
  localparam logic [31:0] FP_EPS_RST  = 32'h3586_37BD;

  localparam int CFG_IDX_W = 3;
  localparam int VP_W      = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VP_LEFT   = 3'd0,
    REG_VP_TOP    = 3'd1,
    REG_VP_WIDTH  = 3'd2,
    REG_VP_HEIGHT = 3'd3,
    REG_DEPTH_MIN = 3'd4,
    REG_DEPTH_MAX = 3'd5,
    REG_ZERO_EPS  = 3'd6
  } pdvm_reg_t;

  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        inf;
    logic        zero;
    logic [7:0]  e;
    logic [23:0] m;
  } pdvm_fp_t;

  // Unrounded value: leading one of mant at bit 26, exp biased.
  typedef struct packed {
    logic               sign;
    logic signed [11:0] exp;
    logic [26:0]        mant;
    logic               spec;
    logic [31:0]        spec_val;
  } pdvm_rnd_t;

  typedef struct packed {
    logic               sign;
    logic signed [11:0] exp;
    logic [47:0]        prod;
    logic               spec;
    logic [31:0]        spec_val;
  } pdvm_mul_t;

  typedef struct packed {
    logic               sign;
    logic signed [11:0] exp;
    logic [27:0]        sum;
    logic               spec;
    logic [31:0]        spec_val;
  } pdvm_add_t;

  typedef struct packed {
    logic               sign;
    logic signed [11:0] ew;
    logic [23:0]        d;
    logic               spec;
    logic [31:0]        spec_val;
    logic [24:0]        rem;
    logic [27:0]        q;
  } pdvm_div_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } pdvm_xyz_t;

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  function automatic pdvm_fp_t unpack(input logic [31:0] f);
    pdvm_fp_t u;
    u.sign = f[31];
    u.nan  = (&f[30:23]) & (|f[22:0]);
    u.inf  = (&f[30:23]) & ~(|f[22:0]);
    u.zero = (f[30:0] == 31'd0);
    u.e    = (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
    u.m    = {(f[30:23] != 8'd0), f[22:0]};
    return u;
  endfunction

  function automatic logic [31:0] round_pack(input pdvm_rnd_t r);
    logic [4:0]         sh;
    logic signed [11:0] shs;
    logic [26:0]        m;
    logic               lost;
    logic [7:0]         e8;
    logic [22:0]        fr;
    logic               g;
    logic               st;
    logic               inc;
    logic [30:0]        mag;
    sh   = '0;
    shs  = '0;
    m    = r.mant;
    lost = 1'b0;
    e8   = '0;
    if (r.spec) return r.spec_val;
    if (r.mant == '0) return {r.sign, 31'd0};
    if (r.exp >= 12'sd255) return {r.sign, 8'hFF, 23'd0};
    if (r.exp >= 12'sd1) begin
      e8 = r.exp[7:0];
    end else begin
      // denormal: shift right into the subnormal range, keep sticky
      shs  = 12'sd1 - r.exp;
      sh   = (shs > 12'sd27) ? 5'd27 : shs[4:0];
      lost = |(r.mant & ~({27{1'b1}} << sh));
      m    = r.mant >> sh;
    end
    fr  = m[25:3];
    g   = m[2];
    st  = m[1] | m[0] | lost;
    inc = g & (st | fr[0]);
    mag = {e8, fr} + 31'(inc);
    return {r.sign, mag};
  endfunction

  function automatic pdvm_mul_t mul_prod(input logic [31:0] a, input logic [31:0] b);
    pdvm_fp_t  ua;
    pdvm_fp_t  ub;
    pdvm_mul_t o;
    ua = unpack(a);
    ub = unpack(b);
    o.sign     = ua.sign ^ ub.sign;
    o.exp      = $signed({4'd0, ua.e}) + $signed({4'd0, ub.e}) - 12'sd126;
    o.prod     = ua.m * ub.m;
    o.spec     = 1'b1;
    o.spec_val = FP_QNAN;
    if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
      o.spec_val = FP_QNAN;
    end else if (ua.inf || ub.inf) begin
      o.spec_val = {o.sign, 8'hFF, 23'd0};
    end else if (ua.zero || ub.zero) begin
      o.spec_val = {o.sign, 31'd0};
    end else begin
      o.spec = 1'b0;
    end
    return o;
  endfunction

  function automatic pdvm_rnd_t mul_norm(input pdvm_mul_t p);
    logic [5:0]  lz;
    logic [47:0] pn;
    pdvm_rnd_t   r;
    lz         = lzc48(p.prod);
    pn         = p.prod << lz;
    r.sign     = p.sign;
    r.exp      = p.exp - $signed({6'd0, lz});
    r.mant     = {pn[47:22], |pn[21:0]};
    r.spec     = p.spec;
    r.spec_val = p.spec_val;
    return r;
  endfunction

  function automatic pdvm_add_t add_align(input logic [31:0] a, input logic [31:0] b);
    pdvm_fp_t  ua;
    pdvm_fp_t  ub;
    pdvm_fp_t  big;
    pdvm_fp_t  sml;
    logic [7:0]  d;
    logic [4:0]  d5;
    logic [26:0] mb;
    logic [26:0] ms;
    logic [26:0] sm;
    logic        lost;
    pdvm_add_t   o;
    ua = unpack(a);
    ub = unpack(b);
    if (a[30:0] >= b[30:0]) begin
      big = ua;
      sml = ub;
    end else begin
      big = ub;
      sml = ua;
    end
    d    = big.e - sml.e;
    d5   = (d > 8'd27) ? 5'd27 : d[4:0];
    mb   = {big.m, 3'd0};
    ms   = {sml.m, 3'd0};
    lost = |(ms & ~({27{1'b1}} << d5));
    sm   = (ms >> d5) | {26'd0, lost};
    o.sign = big.sign;
    o.exp  = $signed({4'd0, big.e});
    if (big.sign == sml.sign) o.sum = {1'b0, mb} + {1'b0, sm};
    else                      o.sum = {1'b0, mb} - {1'b0, sm};
    o.spec     = 1'b1;
    o.spec_val = FP_QNAN;
    if (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.sign != ub.sign))) begin
      o.spec_val = FP_QNAN;
    end else if (ua.inf) begin
      o.spec_val = {ua.sign, 8'hFF, 23'd0};
    end else if (ub.inf) begin
      o.spec_val = {ub.sign, 8'hFF, 23'd0};
    end else if (ua.zero && ub.zero) begin
      o.spec_val = {ua.sign & ub.sign, 31'd0};
    end else begin
      o.spec = 1'b0;
    end
    return o;
  endfunction

  function automatic pdvm_rnd_t add_norm(input pdvm_add_t s);
    logic [5:0]  lz;
    logic [26:0] sn;
    pdvm_rnd_t   r;
    lz         = lzc48({s.sum[26:0], 21'd0});
    sn         = s.sum[26:0] << lz;
    r.spec     = s.spec;
    r.spec_val = s.spec_val;
    // exact cancellation gives +0
    r.sign     = (s.sum == '0) ? 1'b0 : s.sign;
    if (s.sum[27]) begin
      r.mant = {s.sum[27:2], s.sum[1] | s.sum[0]};
      r.exp  = s.exp + 12'sd1;
    end else begin
      r.mant = sn;
      r.exp  = s.exp - $signed({6'd0, lz});
    end
    return r;
  endfunction

  function automatic logic [31:0] fadd_full(input logic [31:0] a, input logic [31:0] b);
    return round_pack(add_norm(add_align(a, b)));
  endfunction

  function automatic logic [31:0] fmul_full(input logic [31:0] a, input logic [31:0] b);
    return round_pack(mul_norm(mul_prod(a, b)));
  endfunction

  // Exact v/2 as a single for a 17-bit unsigned integer.
  function automatic logic [31:0] u2f_half(input logic [16:0] v);
    logic [5:0]  lz;
    logic [16:0] vn;
    lz = lzc48({v, 31'd0});
    vn = v << lz;
    if (v == '0) return 32'd0;
    return {1'b0, 8'd142 - {2'd0, lz}, vn[15:0], 7'd0};
  endfunction

  // Four restoring division steps of 1.0 / d.
  function automatic pdvm_div_t div4(input pdvm_div_t s);
    pdvm_div_t o;
    o = s;
    for (int i = 0; i < 4; i++) begin
      if (o.rem >= {1'b0, o.d}) begin
        o.rem = o.rem - {1'b0, o.d};
        o.q   = {o.q[26:0], 1'b1};
      end else begin
        o.q   = {o.q[26:0], 1'b0};
      end
      o.rem = o.rem << 1;
    end
    return o;
  endfunction

  function automatic pdvm_rnd_t div_fin(input pdvm_div_t s);
    pdvm_rnd_t r;
    logic      st;
    st         = (s.rem != '0);
    r.sign     = s.sign;
    r.spec     = s.spec;
    r.spec_val = s.spec_val;
    if (s.q[27]) begin
      r.mant = {s.q[27:2], s.q[1] | s.q[0] | st};
      r.exp  = 12'sd254 - s.ew;
    end else begin
      r.mant = {s.q[26:1], s.q[0] | st};
      r.exp  = 12'sd253 - s.ew;
    end
    return r;
  endfunction

endpackage

/* sv/pdvm_recip.sv */
// Reciprocal pipeline: 1/w with near-zero override, x/y/z carried along.
// Ten register stages: input, normalize, seven 4-bit divide stages, round.
// Depends on pdvm_pkg.
module pdvm_recip (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_v,
  output logic                in_rdy,
  input  pdvm_pkg::pdvm_xyz_t xyz_i,
  input  logic [31:0]         w_i,
  input  logic [31:0]         eps_i,
  output logic                out_v,
  input  logic                out_rdy,
  output pdvm_pkg::pdvm_xyz_t xyz_o,
  output logic [31:0]         rw_o
);
  import pdvm_pkg::*;

  localparam int NS = 10;

  logic [NS-1:0] v_r;
  logic [NS-1:0] adv;
  pdvm_xyz_t     xyz_r [NS];
  logic [31:0]   w_r;
  pdvm_div_t     div_r [1:8];
  pdvm_div_t     init_nxt;
  logic [31:0]   rw_r;
  pdvm_fp_t      uw;
  logic          eps_nan;
  logic          near;
  logic [5:0]    lz;

  always_comb begin
    adv[NS-1] = !v_r[NS-1] || out_rdy;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  always_comb begin
    uw      = unpack(w_r);
    eps_nan = (&eps_i[30:23]) & (|eps_i[22:0]);
    near    = !uw.nan && !eps_nan && !eps_i[31] && (w_r[30:0] < eps_i[30:0]);
    lz      = lzc48({uw.m, 24'd0});
    init_nxt.sign     = uw.sign;
    init_nxt.ew       = $signed({4'd0, uw.e}) - $signed({6'd0, lz});
    init_nxt.d        = uw.m << lz;
    init_nxt.rem      = 25'd1 << 23;
    init_nxt.q        = '0;
    init_nxt.spec     = 1'b1;
    init_nxt.spec_val = FP_ONE;
    if (near)         init_nxt.spec_val = FP_ONE;
    else if (uw.nan)  init_nxt.spec_val = FP_QNAN;
    else if (uw.inf)  init_nxt.spec_val = {uw.sign, 31'd0};
    else if (uw.zero) init_nxt.spec_val = {uw.sign, 8'hFF, 23'd0};
    else              init_nxt.spec     = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_v;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      xyz_r[0] <= xyz_i;
      w_r      <= w_i;
    end
    for (int i = 1; i < NS; i++) begin
      if (adv[i]) xyz_r[i] <= xyz_r[i-1];
    end
    if (adv[1]) div_r[1] <= init_nxt;
    for (int k = 2; k <= 8; k++) begin
      if (adv[k]) div_r[k] <= div4(div_r[k-1]);
    end
    if (adv[9]) rw_r <= round_pack(div_fin(div_r[8]));
  end

  assign in_rdy = adv[0];
  assign out_v  = v_r[NS-1];
  assign xyz_o  = xyz_r[NS-1];
  assign rw_o   = rw_r;

endmodule

/* sv/pdvm_fmul.sv */
// Three-stage single-precision multiplier lane: product, normalize, round.
// Carries one 32-bit side word along. Depends on pdvm_pkg.
module pdvm_fmul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_v,
  output logic        in_rdy,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] side_i,
  output logic        out_v,
  input  logic        out_rdy,
  output logic [31:0] p_o,
  output logic [31:0] side_o
);
  import pdvm_pkg::*;

  localparam int NS = 3;

  logic [NS-1:0] v_r;
  logic [NS-1:0] adv;
  logic [31:0]   side_r [NS];
  pdvm_mul_t     mul_r;
  pdvm_rnd_t     rnd_r;
  logic [31:0]   p_r;

  always_comb begin
    adv[NS-1] = !v_r[NS-1] || out_rdy;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_v;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      mul_r     <= mul_prod(a_i, b_i);
      side_r[0] <= side_i;
    end
    if (adv[1]) begin
      rnd_r     <= mul_norm(mul_r);
      side_r[1] <= side_r[0];
    end
    if (adv[2]) begin
      p_r       <= round_pack(rnd_r);
      side_r[2] <= side_r[1];
    end
  end

  assign in_rdy = adv[0];
  assign out_v  = v_r[NS-1];
  assign p_o    = p_r;
  assign side_o = side_r[NS-1];

endmodule

/* sv/pdvm_fadd.sv */
// Three-stage single-precision adder lane: align/add, normalize, round.
// Carries one 32-bit side word along. Depends on pdvm_pkg.
module pdvm_fadd (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_v,
  output logic        in_rdy,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] side_i,
  output logic        out_v,
  input  logic        out_rdy,
  output logic [31:0] s_o,
  output logic [31:0] side_o
);
  import pdvm_pkg::*;

  localparam int NS = 3;

  logic [NS-1:0] v_r;
  logic [NS-1:0] adv;
  logic [31:0]   side_r [NS];
  pdvm_add_t     add_r;
  pdvm_rnd_t     rnd_r;
  logic [31:0]   s_r;

  always_comb begin
    adv[NS-1] = !v_r[NS-1] || out_rdy;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_v;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      add_r     <= add_align(a_i, b_i);
      side_r[0] <= side_i;
    end
    if (adv[1]) begin
      rnd_r     <= add_norm(add_r);
      side_r[1] <= side_r[0];
    end
    if (adv[2]) begin
      s_r       <= round_pack(rnd_r);
      side_r[2] <= side_r[1];
    end
  end

  assign in_rdy = adv[0];
  assign out_v  = v_r[NS-1];
  assign s_o    = s_r;
  assign side_o = side_r[NS-1];

endmodule

/* sv/perspective_divide_viewport_map_core.sv */
// Top level of the perspective divide and viewport map block.
// Instantiates pdvm_recip, pdvm_fmul and pdvm_fadd; depends on pdvm_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one clip-space vertex request
//   per cycle while in_stall is low: x, y, z, w as single-precision bit
//   patterns. The result channel (out_valid / out_stall) returns screen x,
//   flipped screen y, mapped depth and 1/w for each request, in order.
//   From acceptance to out_valid a request passes the reciprocal unit
//   (normalize, seven 4-bit restoring-divide stages, round), then three
//   3-stage float lanes (x*rw, viewport scale, viewport offset add).
//   Throughput is one vertex per cycle while out_stall is low; the reciprocal
//   divide is the longest section and is fully pipelined.
//   Each stage has its own valid bit and advances when empty or when the
//   stage after it advances, so bubbles close up and a stalled receiver
//   only backs up the pipeline once all stages hold valid work.
//   Synchronous reset clears all valid bits and loads the register reset
//   values (depth range 0..1, epsilon about 1e-6, zero viewport).
//   Write the registers over cfg_* only while no request is in flight.
//   After a write the viewport terms settle before the depth scale (dadd_r..dscale_r).
module perspective_divide_viewport_map_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [pdvm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   in_clip_x,
  input  logic [31:0]                   in_clip_y,
  input  logic [31:0]                   in_clip_z,
  input  logic [31:0]                   in_clip_w,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_screen_x,
  output logic [31:0]                   out_screen_y,
  output logic [31:0]                   out_depth_out,
  output logic [31:0]                   out_recip_w
);
  import pdvm_pkg::*;

  // Configuration registers
  logic [VP_W-1:0] vp_left_r;
  logic [VP_W-1:0] vp_top_r;
  logic [VP_W-1:0] vp_width_r;
  logic [VP_W-1:0] vp_height_r;
  logic [31:0]     depth_min_r;
  logic [31:0]     depth_max_r;
  logic [31:0]     zero_eps_r;

  // Derived terms, all exact except the depth scale
  logic [31:0] hw_r;
  logic [31:0] hh_r;
  logic [31:0] cx_r;
  logic [31:0] cy_r;
  pdvm_add_t   dadd_r;
  pdvm_rnd_t   dnorm_r;
  logic [31:0] dsub_r;
  pdvm_mul_t   dmul_r;
  pdvm_rnd_t   dmnorm_r;
  logic [31:0] dscale_r;

  pdvm_xyz_t   in_xyz;
  pdvm_xyz_t   rc_xyz;
  logic        rc_v;
  logic        rc_rdy;
  logic [31:0] rc_rw;

  logic        m1_rdy_x;
  logic        m1_rdy_y;
  logic        m1_rdy_z;
  logic        m1_v;
  logic        m1_v_y;
  logic        m1_v_z;
  logic [31:0] px;
  logic [31:0] py;
  logic [31:0] pz;
  logic [31:0] m1_rw;
  logic [31:0] m1_side_y;
  logic [31:0] m1_side_z;

  logic        m2_rdy_x;
  logic        m2_rdy_y;
  logic        m2_rdy_z;
  logic        m2_v;
  logic        m2_v_y;
  logic        m2_v_z;
  logic [31:0] tx;
  logic [31:0] ty;
  logic [31:0] tz;
  logic [31:0] m2_rw;
  logic [31:0] m2_side_y;
  logic [31:0] m2_side_z;

  logic        a_rdy_x;
  logic        a_rdy_y;
  logic        a_rdy_z;
  logic        a_v_y;
  logic        a_v_z;
  logic [31:0] a_side_y;
  logic [31:0] a_side_z;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_left_r   <= '0;
      vp_top_r    <= '0;
      vp_width_r  <= '0;
      vp_height_r <= '0;
      depth_min_r <= '0;
      depth_max_r <= FP_DMAX_RST;
      zero_eps_r  <= FP_EPS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_VP_LEFT:   vp_left_r   <= cfg_data[VP_W-1:0];
        REG_VP_TOP:    vp_top_r    <= cfg_data[VP_W-1:0];
        REG_VP_WIDTH:  vp_width_r  <= cfg_data[VP_W-1:0];
        REG_VP_HEIGHT: vp_height_r <= cfg_data[VP_W-1:0];
        REG_DEPTH_MIN: depth_min_r <= cfg_data;
        REG_DEPTH_MAX: depth_max_r <= cfg_data;
        REG_ZERO_EPS:  zero_eps_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Half sizes and centers: origin + size/2 computed as (2*origin + size)/2.
  // Depth scale runs through the same align/normalize/round and product/normalize/round splits as the lanes.
  always_ff @(posedge clk) begin
    hw_r     <= u2f_half({2'b0, vp_width_r});
    hh_r     <= u2f_half({2'b0, vp_height_r});
    cx_r     <= u2f_half(17'({vp_left_r, 1'b0}) + 17'(vp_width_r));
    cy_r     <= u2f_half(17'({vp_top_r, 1'b0}) + 17'(vp_height_r));
    dadd_r   <= add_align(depth_max_r, depth_min_r ^ FP_SIGN);
    dnorm_r  <= add_norm(dadd_r);
    dsub_r   <= round_pack(dnorm_r);
    dmul_r   <= mul_prod(dsub_r, FP_HALF);
    dmnorm_r <= mul_norm(dmul_r);
    dscale_r <= round_pack(dmnorm_r);
  end

  assign in_xyz.x = in_clip_x;
  assign in_xyz.y = in_clip_y;
  assign in_xyz.z = in_clip_z;

  // 1/w, or one when |w| is under the epsilon
  pdvm_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (in_valid),
    .in_rdy  (rc_rdy),
    .xyz_i   (in_xyz),
    .w_i     (in_clip_w),
    .eps_i   (zero_eps_r),
    .out_v   (rc_v),
    .out_rdy (m1_rdy_x),
    .xyz_o   (rc_xyz),
    .rw_o    (rc_rw)
  );

  assign in_stall = !rc_rdy;

  // Perspective divide: the three lanes run in lockstep, lane x carries rw
  pdvm_fmul u_mul_px (
    .clk (clk), .rst_n (rst_n), .in_v (rc_v), .in_rdy (m1_rdy_x),
    .a_i (rc_xyz.x), .b_i (rc_rw), .side_i (rc_rw),
    .out_v (m1_v), .out_rdy (m2_rdy_x), .p_o (px), .side_o (m1_rw)
  );
  pdvm_fmul u_mul_py (
    .clk (clk), .rst_n (rst_n), .in_v (rc_v), .in_rdy (m1_rdy_y),
    .a_i (rc_xyz.y), .b_i (rc_rw), .side_i (rc_rw),
    .out_v (m1_v_y), .out_rdy (m2_rdy_x), .p_o (py), .side_o (m1_side_y)
  );
  pdvm_fmul u_mul_pz (
    .clk (clk), .rst_n (rst_n), .in_v (rc_v), .in_rdy (m1_rdy_z),
    .a_i (rc_xyz.z), .b_i (rc_rw), .side_i (rc_rw),
    .out_v (m1_v_z), .out_rdy (m2_rdy_x), .p_o (pz), .side_o (m1_side_z)
  );

  // Viewport and depth scale; y is negated to flip it
  pdvm_fmul u_mul_tx (
    .clk (clk), .rst_n (rst_n), .in_v (m1_v), .in_rdy (m2_rdy_x),
    .a_i (hw_r), .b_i (px), .side_i (m1_rw),
    .out_v (m2_v), .out_rdy (a_rdy_x), .p_o (tx), .side_o (m2_rw)
  );
  pdvm_fmul u_mul_ty (
    .clk (clk), .rst_n (rst_n), .in_v (m1_v_y), .in_rdy (m2_rdy_y),
    .a_i (hh_r), .b_i (py ^ FP_SIGN), .side_i (m1_side_y),
    .out_v (m2_v_y), .out_rdy (a_rdy_x), .p_o (ty), .side_o (m2_side_y)
  );
  pdvm_fmul u_mul_tz (
    .clk (clk), .rst_n (rst_n), .in_v (m1_v_z), .in_rdy (m2_rdy_z),
    .a_i (dscale_r), .b_i (pz), .side_i (m1_side_z),
    .out_v (m2_v_z), .out_rdy (a_rdy_x), .p_o (tz), .side_o (m2_side_z)
  );

  // Offset by the viewport center and near depth; last stage is the output register
  pdvm_fadd u_add_sx (
    .clk (clk), .rst_n (rst_n), .in_v (m2_v), .in_rdy (a_rdy_x),
    .a_i (tx), .b_i (cx_r), .side_i (m2_rw),
    .out_v (out_valid), .out_rdy (!out_stall), .s_o (out_screen_x),
    .side_o (out_recip_w)
  );
  pdvm_fadd u_add_sy (
    .clk (clk), .rst_n (rst_n), .in_v (m2_v_y), .in_rdy (a_rdy_y),
    .a_i (ty), .b_i (cy_r), .side_i (m2_side_y),
    .out_v (a_v_y), .out_rdy (!out_stall), .s_o (out_screen_y),
    .side_o (a_side_y)
  );
  pdvm_fadd u_add_sz (
    .clk (clk), .rst_n (rst_n), .in_v (m2_v_z), .in_rdy (a_rdy_z),
    .a_i (tz), .b_i (depth_min_r), .side_i (m2_side_z),
    .out_v (a_v_z), .out_rdy (!out_stall), .s_o (out_depth_out),
    .side_o (a_side_z)
  );

endmodule

/* dv/perspective_divide_viewport_map_core_tb.sv */
// Testbench for perspective_divide_viewport_map_core: random and directed vertex requests,
// an independent float predictor for screen x/y, depth and 1/w, checked in order.
// Depends on pdvm_pkg (register index names) and the core itself.
`timescale 1ns / 100ps

module perspective_divide_viewport_map_core_tb;
  import pdvm_pkg::*;

  localparam logic [31:0] QNAN_PAT = 32'h7FC0_0000;
  // Index past the last register; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] sz;
    logic [31:0] rw;
  } screen_vtx_t;

  // Round a double to the nearest single (ties to even, gradual underflow).
  // The double carries more than twice the single precision, so one exact
  // double operation followed by this rounding equals a direct single op.
  function automatic logic [31:0] to_single(input real r);
    logic [63:0] d;
    logic [63:0] m;
    logic [63:0] sig;
    logic [63:0] mag;
    logic        s;
    logic        g;
    logic        st;
    int          e;
    int          sh;
    d = $realtobits(r);
    s = d[63];
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? QNAN_PAT : {s, 8'hFF, 23'd0};
    if (d[62:0] == 63'd0) return {s, 31'd0};
    e = int'(d[62:52]) - 1023 + 127;
    if (e >= 255) return {s, 8'hFF, 23'd0};
    m  = {11'd0, 1'b1, d[51:0]};
    sh = (e >= 1) ? 29 : 30 - e;
    if (sh > 60) begin
      sig = 0;
      g   = 1'b0;
      st  = 1'b1;
    end else begin
      sig = m >> sh;
      g   = m[sh-1];
      st  = (m & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
    end
    mag = (64'((e >= 1) ? e - 1 : 0) << 23) + sig + 64'(g & (st | sig[0]));
    if (mag >= 64'h7F80_0000) return {s, 8'hFF, 23'd0};
    return {s, mag[30:0]};
  endfunction

  function automatic real to_double(input logic [31:0] f);
    real v;
    if (f[30:23] == 8'hFF)
      return $bitstoreal({f[31], 11'h7FF, (f[22:0] != 0) ? 52'h8_0000_0000_0000 : 52'd0});
    if (f[30:23] == 8'd0) begin
      v = real'(f[22:0]) * (2.0 ** (-149));
      return f[31] ? -v : v;
    end
    return $bitstoreal({f[31], 11'(int'(f[30:23]) + 896), f[22:0], 29'd0});
  endfunction

  function automatic real rnd(input real r);
    return to_double(to_single(r));
  endfunction

  // Register copy plus the ordered list of screen results still owed.
  class screen_board;
    logic [31:0] view_regs[7];
    screen_vtx_t pending_screen[$];

    function void reset_regs();
      foreach (view_regs[i]) view_regs[i] = 32'd0;
      view_regs[REG_DEPTH_MAX] = 32'h3F80_0000;
      view_regs[REG_ZERO_EPS]  = 32'h3586_37BD;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
      if (idx > REG_ZERO_EPS) return;
      view_regs[idx] = (idx <= REG_VP_HEIGHT) ? (val & 32'h7FFF) : val;
    endfunction

    function int count();
      return pending_screen.size();
    endfunction

    function void note_vertex(input logic [31:0] x, y, z, w);
      real rw, px, py, pz, hw, hh, cx, cy, dmin, dsc;
      screen_vtx_t e;
      if (to_double({1'b0, w[30:0]}) < to_double(view_regs[REG_ZERO_EPS])) rw = 1.0;
      else rw = rnd(1.0 / to_double(w));
      px   = rnd(to_double(x) * rw);
      py   = rnd(to_double(y) * rw);
      pz   = rnd(to_double(z) * rw);
      hw   = real'(view_regs[REG_VP_WIDTH]) * 0.5;
      hh   = real'(view_regs[REG_VP_HEIGHT]) * 0.5;
      cx   = rnd(real'(view_regs[REG_VP_LEFT]) + hw);
      cy   = rnd(real'(view_regs[REG_VP_TOP]) + hh);
      dmin = to_double(view_regs[REG_DEPTH_MIN]);
      dsc  = rnd(rnd(to_double(view_regs[REG_DEPTH_MAX]) - dmin) * 0.5);
      e.sx = to_single(rnd(hw * px) + cx);
      e.sy = to_single(rnd(hh * (-py)) + cy);
      e.sz = to_single(rnd(dsc * pz) + dmin);
      e.rw = to_single(rw);
      pending_screen.push_back(e);
    endfunction

    // Returns an empty string when the result matches the oldest expectation.
    function string check_screen(input logic [31:0] sx, sy, sz, rw);
      screen_vtx_t e;
      string msg;
      if (pending_screen.size() == 0) return "result with nothing outstanding";
      e = pending_screen.pop_front();
      msg = "";
      if (sx !== e.sx) msg = {msg, $sformatf(" screen_x %h exp %h", sx, e.sx)};
      if (sy !== e.sy) msg = {msg, $sformatf(" screen_y %h exp %h", sy, e.sy)};
      if (sz !== e.sz) msg = {msg, $sformatf(" depth %h exp %h", sz, e.sz)};
      if (rw !== e.rw) msg = {msg, $sformatf(" recip_w %h exp %h", rw, e.rw)};
      return msg;
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [31:0]          in_clip_x;
  logic [31:0]          in_clip_y;
  logic [31:0]          in_clip_z;
  logic [31:0]          in_clip_w;
  logic                 out_valid;
  logic                 out_stall;
  logic [31:0]          out_screen_x;
  logic [31:0]          out_screen_y;
  logic [31:0]          out_depth_out;
  logic [31:0]          out_recip_w;

  screen_board board;
  int          mismatches;
  bit          quiet;      // no idling on either side while set
  int          stall_hold;

  perspective_divide_viewport_map_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_clip_x    (in_clip_x),
    .in_clip_y    (in_clip_y),
    .in_clip_z    (in_clip_z),
    .in_clip_w    (in_clip_w),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_screen_x (out_screen_x),
    .out_screen_y (out_screen_y),
    .out_depth_out(out_depth_out),
    .out_recip_w  (out_recip_w)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report(input string msg);
    mismatches++;
    $display("mismatch at %0t:%s", $realtime, msg);
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random single: full bit noise, moderate, tiny and huge values, specials.
  function automatic logic [31:0] rand_float();
    logic [31:0] specials[8];
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'h0000_0001, 32'h7F7F_FFFF, 32'h3F80_0000};
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      7:       return {1'($urandom), 8'($urandom_range(0, 115)), 23'($urandom)};
      8:       return specials[$urandom_range(0, 7)];
      9:       return {1'($urandom), 8'($urandom_range(138, 254)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(117, 137)), 23'($urandom)};
    endcase
  endfunction

  // Hold a request until accepted; valid stays high across back-to-back requests.
  task automatic send_vertex(input logic [31:0] x, y, z, w);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_clip_x <= x;
    in_clip_y <= y;
    in_clip_z <= z;
    in_clip_w <= w;
    do @(posedge clk); while (in_stall);
    board.note_vertex(x, y, z, w);
  endtask

  // Drop valid and wait for every owed result, then a little slack.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.count() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.set_reg(idx, val);
  endtask

  task automatic load_view(input logic [31:0] l, t, wd, ht, dmin, dmax, eps);
    drain();
    cfg_write(REG_VP_LEFT, l);
    cfg_write(REG_VP_TOP, t);
    cfg_write(REG_VP_WIDTH, wd);
    cfg_write(REG_VP_HEIGHT, ht);
    cfg_write(REG_DEPTH_MIN, dmin);
    cfg_write(REG_DEPTH_MAX, dmax);
    cfg_write(REG_ZERO_EPS, eps);
    // let the derived viewport and depth terms settle
    repeat (4) @(negedge clk);
  endtask

  // Receiver: random stall, mostly short, occasionally a long hold.
  initial begin
    out_stall  = 1'b0;
    stall_hold = 0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        stall_hold = 0;
        out_stall <= 1'b0;
      end else if (stall_hold > 0) begin
        stall_hold--;
        out_stall <= 1'b1;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:79]:  out_stall <= 1'b0;
          [80:96]: begin
            out_stall  <= 1'b1;
            stall_hold = $urandom_range(0, 3);
          end
          default: begin
            out_stall  <= 1'b1;
            stall_hold = $urandom_range(10, 40);
          end
        endcase
      end
    end
  end

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && !out_stall) begin
      msg = board.check_screen(out_screen_x, out_screen_y, out_depth_out, out_recip_w);
      if (msg != "") report(msg);
    end
  end

  initial begin
    logic [31:0] dmin;
    board = new();
    board.reset_regs();
    mismatches = 0;
    quiet      = 1'b0;
    rst_n      = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = REG_VP_LEFT;
    cfg_data   = 32'd0;
    in_valid   = 1'b0;
    in_clip_x  = 32'd0;
    in_clip_y  = 32'd0;
    in_clip_z  = 32'd0;
    in_clip_w  = 32'd0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Directed part at the reset register values, then on a real viewport.
    send_vertex(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
    load_view(32'd100, 32'd50, 32'd640, 32'd480, 32'h0000_0000, 32'h3F80_0000,
              32'h3586_37BD);
    send_vertex(32'h3F00_0000, 32'hBF00_0000, 32'h3E80_0000, 32'h4000_0000);
    // zero w of either sign: below epsilon, reciprocal is one
    send_vertex(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000);
    send_vertex(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h8000_0000);
    // w just under, exactly at and just over the threshold
    send_vertex(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h3586_37BC);
    send_vertex(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'hB586_37BD);
    send_vertex(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h3586_37BE);
    // infinite and NaN w
    send_vertex(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h7F80_0000);
    send_vertex(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'hFF80_0000);
    send_vertex(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h7FC0_0001);
    // field extremes
    send_vertex(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h3F80_0000);
    send_vertex(32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF, 32'h3F80_0000);
    send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_vertex(32'h7F80_0000, 32'hFF80_0000, 32'h0000_0000, 32'h3F80_0000);
    send_vertex(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h7F7F_FFFF);
    send_vertex(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0080_0000);
    // NaN and negative epsilon: the compare fails, so 1/w is taken
    load_view(32'd0, 32'd0, 32'd16384, 32'd16384, 32'hBF80_0000, 32'h3F80_0000,
              32'h7FC0_0000);
    send_vertex(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000);
    send_vertex(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h0000_0010);
    load_view(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3F80_0000,
              32'h0000_0000, 32'hBF80_0000);
    cfg_write(REG_NONE, 32'h1234_5678);
    send_vertex(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000);
    send_vertex(32'h4080_0000, 32'hC080_0000, 32'h4080_0000, 32'hC000_0000);

    // Random phases, each under its own register setting.
    for (int p = 0; p < 11; p++) begin
      case (p)
        0: load_view(32'd16384, 32'd16384, 32'd16384, 32'd16384, 32'h7F7F_FFFF,
                     32'hFF7F_FFFF, 32'h7F7F_FFFF);
        1: load_view(32'd0, 32'd0, 32'd0, 32'd0, 32'h0000_0000, 32'h0000_0000,
                     32'h0000_0000);
        2: load_view(32'd0, 32'd0, 32'd1920, 32'd1080, 32'h0000_0000, 32'h3F80_0000,
                     32'h3586_37BD);
        default: begin
          dmin = ($urandom_range(0, 1) != 0) ? 32'h0000_0000 : rand_float();
          load_view($urandom_range(0, 16384), $urandom_range(0, 16384),
                    $urandom_range(0, 16384), $urandom_range(0, 16384), dmin,
                    ($urandom_range(0, 1) != 0) ? 32'h3F80_0000 : rand_float(),
                    ($urandom_range(0, 2) != 0) ? 32'h3586_37BD : rand_float());
        end
      endcase
      if (p == 4) cfg_write(REG_NONE, $urandom);
      quiet = (p % 4 == 3);
      for (int i = 0; i < 50; i++) begin
        // hold the sender until everything owed is back
        if (p == 5 && i == 25) drain();
        send_vertex(rand_float(), rand_float(), rand_float(),
                    ($urandom_range(0, 5) == 0)
                      ? {1'($urandom), 8'($urandom_range(100, 110)), 23'($urandom)}
                      : rand_float());
      end
    end
    quiet = 1'b0;

    drain();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && board.count() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/pdvm_pkg.sv
sv/pdvm_recip.sv
sv/pdvm_fmul.sv
sv/pdvm_fadd.sv
sv/perspective_divide_viewport_map_core.sv
dv/perspective_divide_viewport_map_core_tb.sv
